[rtl/ihex_pkg.sv]
// Shared types, result codes and the hex digit decoder for the HEX record parser.
// No dependencies.
`timescale 1ns / 1ps

package ihex_pkg;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_OK     = 2'd1;
   localparam logic [1:0] KIND_SUM    = 2'd2;
   localparam logic [1:0] KIND_FORMAT = 2'd3;

   localparam logic [7:0] TYPE_DATA  = 8'h00;
   localparam logic [7:0] TYPE_UPPER = 8'h04;

   localparam int POS_W = 10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [15:0] byte_address;
      logic [15:0] upper_address;
      logic [7:0]  record_type;
      logic [7:0]  record_length;
      logic [15:0] record_address;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   // ASCII hex digit to nibble; ok is low for anything that is not 0-9, A-F or a-f.
   function automatic digit_type hex_decode(input logic [7:0] c);
      digit_type d;
      d.ok    = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h57);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

[rtl/intel_hex_record_parser_core.sv]
// Intel HEX record parser, one ASCII character per input beat.
//
// Input channel (req_): one character per beat; req_line_start marks the first character
// of a record, which is skipped. The characters after it are read as hex digit pairs:
// length, address (high byte first), type, data bytes, checksum.
// Result channel (rsp_): a data byte with its address for every byte of a type-00 record,
// then one record result: accepted, checksum mismatch or format error. A bad digit or a
// record cut short by a new start gives a format error.
// A result is held in the result register before it appears on rsp_. One character is
// taken every cycle while req_stall is low; the decode and field update sit between the
// record state registers and the result register. A skid entry behind the result
// register lets one more result in while rsp_stall holds; req_stall rises only when both
// entries are full, and falls the cycle after the receiver takes a beat.
// Synchronous reset clears the record state, the upper address and both result entries;
// the block then waits for a record start.
// Depends on ihex_pkg, ihex_parse and ihex_out_buf.
`timescale 1ns / 1ps

module intel_hex_record_parser_core import ihex_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_line_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_byte_address,
   output logic [15:0] rsp_upper_address,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_record_length,
   output logic [15:0] rsp_record_address
);

   logic       accept;
   logic       res_valid;
   logic       full;
   result_type res;
   result_type out_data;

   assign accept    = req_valid & ~full;
   assign req_stall = full;

   ihex_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .character  (req_character),
      .line_start (req_line_start),
      .res_valid  (res_valid),
      .res        (res)
   );

   ihex_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_kind           = out_data.kind;
   assign rsp_byte_value     = out_data.byte_value;
   assign rsp_byte_address   = out_data.byte_address;
   assign rsp_upper_address  = out_data.upper_address;
   assign rsp_record_type    = out_data.record_type;
   assign rsp_record_length  = out_data.record_length;
   assign rsp_record_address = out_data.record_address;

endmodule

[rtl/ihex_parse.sv]
// Record state and per-character decode: updates the record fields on each accepted beat
// and produces at most one result for it. Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_parse import ihex_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] character,
   input  logic       line_start,
   output logic       res_valid,
   output result_type res
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       high_ff, high_in;
   logic [7:0]       len_ff, len_in;
   logic [15:0]      addr_ff, addr_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       sum_ff, sum_in;
   logic [15:0]      pend_ff, pend_in;
   logic [15:0]      upper_ff, upper_in;
   logic             in_rec_ff, in_rec_in;
   logic             err_ff, err_in;

   digit_type        dig;
   logic [7:0]       byte_val;
   logic [8:0]       bidx;
   logic [8:0]       idx;
   logic             sum_good;

   assign dig      = hex_decode(character);
   assign byte_val = {high_ff, dig.value};
   // Byte index within the record; only used on even positions, which are at least two.
   assign bidx     = pos_ff[POS_W-1:1] - 9'd1;
   assign idx      = bidx - 9'd4;
   assign sum_good = (8'(8'h00 - sum_ff) == byte_val);

   always_comb begin
      pos_in    = pos_ff;
      high_in   = high_ff;
      len_in    = len_ff;
      addr_in   = addr_ff;
      type_in   = type_ff;
      sum_in    = sum_ff;
      pend_in   = pend_ff;
      upper_in  = upper_ff;
      in_rec_in = in_rec_ff;
      err_in    = err_ff;
      res_valid = 1'b0;
      res.kind           = KIND_FORMAT;
      res.byte_value     = 8'd0;
      res.byte_address   = 16'd0;
      res.upper_address  = upper_ff;
      res.record_type    = type_ff;
      res.record_length  = len_ff;
      res.record_address = addr_ff;

      if (accept) begin
         if (line_start) begin
            // A start while a record is open reports the old one as cut short.
            res_valid = in_rec_ff;
            in_rec_in = 1'b1;
            err_in    = 1'b0;
            pos_in    = POS_W'(1);
            high_in   = 4'd0;
            len_in    = 8'd0;
            addr_in   = 16'd0;
            type_in   = 8'd0;
            sum_in    = 8'd0;
            pend_in   = 16'd0;
         end else if (in_rec_ff) begin
            if (!dig.ok) begin
               res_valid = 1'b1;
               in_rec_in = 1'b0;
               err_in    = 1'b1;
            end else if (pos_ff[0]) begin
               high_in = dig.value;
               pos_in  = pos_ff + POS_W'(1);
            end else begin
               pos_in = pos_ff + POS_W'(1);
               if (bidx == 9'd4 + {1'b0, len_ff}) begin
                  in_rec_in = 1'b0;
                  res_valid = 1'b1;
                  if (sum_good) begin
                     res.kind = KIND_OK;
                     if (type_ff == TYPE_UPPER) begin
                        upper_in          = pend_ff;
                        res.upper_address = pend_ff;
                     end
                  end else begin
                     res.kind = KIND_SUM;
                  end
               end else begin
                  sum_in = sum_ff + byte_val;
                  case (bidx)
                     9'd0: len_in = byte_val;
                     9'd1: addr_in = {byte_val, 8'd0};
                     9'd2: addr_in = {addr_ff[15:8], byte_val};
                     9'd3: type_in = byte_val;
                     default: begin
                        if (type_ff == TYPE_DATA) begin
                           res_valid        = 1'b1;
                           res.kind         = KIND_DATA;
                           res.byte_value   = byte_val;
                           res.byte_address = addr_ff + {7'd0, idx};
                        end else if (type_ff == TYPE_UPPER) begin
                           if (idx == 9'd0) begin
                              pend_in = {byte_val, pend_ff[7:0]};
                           end else if (idx == 9'd1) begin
                              pend_in = {pend_ff[15:8], byte_val};
                           end
                        end
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         high_ff   <= '0;
         len_ff    <= '0;
         addr_ff   <= '0;
         type_ff   <= '0;
         sum_ff    <= '0;
         pend_ff   <= '0;
         upper_ff  <= '0;
         in_rec_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         high_ff   <= high_in;
         len_ff    <= len_in;
         addr_ff   <= addr_in;
         type_ff   <= type_in;
         sum_ff    <= sum_in;
         pend_ff   <= pend_in;
         upper_ff  <= upper_in;
         in_rec_ff <= in_rec_in;
         err_ff    <= err_in | (err_ff & ~in_rec_in);
      end
   end

endmodule

[rtl/ihex_out_buf.sv]
// Result register with a skid entry, so the input side keeps moving while a result waits.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_out_buf import ihex_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       main_v_ff, main_v_in;
   logic       skid_v_ff, skid_v_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       moving;

   assign moving    = main_v_ff & ~out_stall;
   assign full      = skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_v_in = main_v_ff & ~moving;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (moving) begin
            main_in   = skid_ff;
            main_v_in = 1'b1;
            skid_v_in = 1'b0;
         end
      end else if (in_valid) begin
         // New beats only arrive while the skid entry is empty.
         if (!main_v_ff || moving) begin
            main_in   = in_data;
            main_v_in = 1'b1;
         end else begin
            skid_in   = in_data;
            skid_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
